[design/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/bfs_pkg.sv]
// types and constants of the bounded fifo with search
package bfs_pkg;

   localparam int VALUE_W       = 32;
   localparam int CAP_W         = 6;
   localparam int DEFAULT_DEPTH = 32;
   localparam int RESULT_LIMIT  = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_QUERY   = 2'd2,
      ACT_DUMP    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_ENQUEUED   = 3'd0,
      KIND_OVERFLOW   = 3'd1,
      KIND_DEQUEUED   = 3'd2,
      KIND_UNDERFLOW  = 3'd3,
      KIND_FOUND      = 3'd4,
      KIND_NOT_FOUND  = 3'd5,
      KIND_DUMP_ENTRY = 3'd6,
      KIND_DUMP_EMPTY = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [VALUE_W-1:0]  value;
      logic                       last;
   } result_type;

endpackage

[design/bfs_ram.sv]
// generic single-clock ram with one write port and one registered read port
module bfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bfs_out_reg.sv]
// output register between the engine and the result channel
module bfs_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bfs_pkg::result_type push_data,
   output logic                free,
   output logic                out_valid,
   input  logic                out_ready,
   output bfs_pkg::result_type out_data
);

   import bfs_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[design/bfs_engine.sv]
// queue sequencer: pointers, count and entry walk over the entry ram
module bfs_engine #(
   parameter int QUEUE_DEPTH = bfs_pkg::DEFAULT_DEPTH,
   parameter int CNT_W       = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bfs_pkg::action_type               req_action,
   input  logic signed [bfs_pkg::VALUE_W-1:0] req_value,
   input  logic [CNT_W-1:0]                  allowed,
   input  logic                              out_free,
   output logic                              push,
   output bfs_pkg::result_type               push_data,
   output logic [CNT_W-1:0]                  count
);

   import bfs_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] nxt;
      if (slot == IDX_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + 1'b1;
      end
      return nxt;
   endfunction

   state_type                 state_ff, state_in;
   action_type                act_ff, act_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [IDX_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          len_ff, len_in;
   logic                      hit_ff, hit_in;

   logic                      ram_we;
   logic                      ram_re;
   logic [IDX_W-1:0]          ram_raddr;
   logic [VALUE_W-1:0]        ram_rdata;

   logic full;
   logic empty;
   logic last_entry;
   logic consume;
   logic single_done;
   logic accept;

   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign full        = count_ff >= allowed;
   assign empty       = count_ff == '0;
   assign last_entry  = (idx_ff + 1'b1) == len_ff;
   assign consume     = (state_ff == ST_SCAN)
                        && (out_free || (act_ff == ACT_QUERY && !last_entry));
   assign single_done = (state_ff == ST_EXEC) && out_free
                        && (act_ff == ACT_ENQUEUE || empty);

   bfs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (val_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (act_ff != ACT_ENQUEUE && !empty) begin
               state_in = ST_SCAN;
            end else if (single_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (consume && last_entry) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      act_in    = act_ff;
      val_in    = val_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      hit_in    = hit_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = next_slot(ptr_ff);
      push      = 1'b0;
      push_data = '{kind: KIND_OVERFLOW, value: '0, last: 1'b1};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in = req_action;
               val_in = req_value;
               hit_in = 1'b0;
            end
         end
         ST_EXEC: begin
            if (act_ff != ACT_ENQUEUE && !empty) begin
               ram_re    = 1'b1;
               ram_raddr = head_ff;
               ptr_in    = head_ff;
               idx_in    = '0;
               len_in    = (act_ff == ACT_DEQUEUE) ? CNT_W'(1) : count_ff;
            end else if (single_done) begin
               push = 1'b1;
               unique case (act_ff)
                  ACT_ENQUEUE: begin
                     if (full) begin
                        push_data.kind = KIND_OVERFLOW;
                     end else begin
                        push_data.kind  = KIND_ENQUEUED;
                        push_data.value = val_ff;
                        ram_we          = 1'b1;
                        tail_in         = next_slot(tail_ff);
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  ACT_DEQUEUE: push_data.kind = KIND_UNDERFLOW;
                  ACT_QUERY: begin
                     push_data.kind  = KIND_NOT_FOUND;
                     push_data.value = val_ff;
                  end
                  ACT_DUMP: push_data.kind = KIND_DUMP_EMPTY;
                  default: push_data.kind = KIND_OVERFLOW;
               endcase
            end
         end
         ST_SCAN: begin
            if (consume) begin
               hit_in = hit_ff || (ram_rdata == val_ff);
               if (!last_entry) begin
                  ram_re = 1'b1;
                  ptr_in = next_slot(ptr_ff);
                  idx_in = idx_ff + 1'b1;
               end
               unique case (act_ff)
                  ACT_DEQUEUE: begin
                     push            = 1'b1;
                     push_data.kind  = KIND_DEQUEUED;
                     push_data.value = ram_rdata;
                     head_in         = next_slot(head_ff);
                     count_in        = count_ff - 1'b1;
                  end
                  ACT_QUERY: begin
                     push            = last_entry;
                     push_data.kind  = (hit_ff || ram_rdata == val_ff)
                                       ? KIND_FOUND : KIND_NOT_FOUND;
                     push_data.value = val_ff;
                  end
                  ACT_DUMP: begin
                     push            = 1'b1;
                     push_data.kind  = KIND_DUMP_ENTRY;
                     push_data.value = ram_rdata;
                     push_data.last  = last_entry;
                  end
                  default: push = 1'b0;
               endcase
            end
         end
         default: push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      val_ff <= val_in;
      ptr_ff <= ptr_in;
      idx_ff <= idx_in;
      len_ff <= len_in;
      hit_ff <= hit_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign count     = count_ff;

endmodule

[design/bounded_fifo_with_search.sv]
// top level of the bounded fifo with search
//
// req channel: one transaction per action; tuser selects enqueue, dequeue,
// query or dump and tdata carries the value. rsp channel: tuser gives the
// result kind, tdata the value and tlast marks the final result of an action.
// csr_we writes the capacity limit (effective limit is the smallest of the
// capacity, the queue depth and 32); write it only while the block is idle.
// Entries live in a ram with a registered read port; actions are handled
// one at a time. Enqueue, overflow, underflow and empty cases load their
// result into the output register from the exec state; dequeue reads the
// head entry in exec and loads it from scan. Query walks every stored
// entry through the ram read port; dump emits one entry per cycle while
// the output register is free. A new request is taken in the cycle after
// the last result is loaded. The output register keeps one result; while
// it is full and rsp_tready is low, no result is loaded. Reset empties the
// queue and output register and sets capacity to 32; ram is not cleared.
`include "assert_macros.svh"

module bounded_fifo_with_search #(
   parameter int QUEUE_DEPTH = bfs_pkg::DEFAULT_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // [31:0] value
   input  logic [1:0]                 req_tuser,   // [1:0] action
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,   // [31:0] result_value
   output logic [2:0]                 rsp_tuser,   // [2:0] result_kind
   output logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [bfs_pkg::CAP_W-1:0]  csr_wdata
);

   import bfs_pkg::*;

   localparam int LIMIT = (QUEUE_DEPTH < RESULT_LIMIT) ? QUEUE_DEPTH : RESULT_LIMIT;
   localparam int CNT_W = $clog2(LIMIT + 1);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic [CNT_W-1:0] allowed;
   logic [CNT_W-1:0] count;
   logic             push;
   logic             out_free;
   result_type       push_data;
   result_type       out_data;

   assign capacity_in = csr_we ? csr_wdata : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      if (int'(capacity_ff) > LIMIT) begin
         allowed = CNT_W'(LIMIT);
      end else begin
         allowed = CNT_W'(capacity_ff);
      end
   end

   bfs_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CNT_W       (CNT_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (action_type'(req_tuser)),
      .req_value  (req_tdata),
      .allowed    (allowed),
      .out_free   (out_free),
      .push       (push),
      .push_data  (push_data),
      .count      (count)
   );

   bfs_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .free      (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = out_data.value;
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

   `ASSERT_ALWAYS(a_count_limit, clock, reset, int'(count) <= LIMIT, "entry count above limit")
   `ASSERT_ALWAYS(a_no_overwrite, clock, reset, !(push && !out_free), "result overwritten")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready, "busy accept")

endmodule

[tb/tb.sv]
// self-checking testbench of the bounded fifo with search
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bfs_pkg::*;

   localparam int DEPTH          = DEFAULT_DEPTH;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int MAX_REPORTS    = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;
   logic [1:0]        req_tuser = ACT_ENQUEUE;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic [2:0]        rsp_tuser;
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic [CAP_W-1:0]  csr_wdata = '0;

   // queue model state
   logic [31:0]       fifo_mem [DEPTH];
   int                fifo_head = 0;
   int                fifo_tail = 0;
   int                fifo_count = 0;
   logic [CAP_W-1:0]  cap_reg = CAP_RESET;

   result_type        pending_results [$];
   int                error_count = 0;
   int                items_sent = 0;
   int                results_checked = 0;
   int                cap_writes = 0;
   int                longest_dump = 0;
   int                idle_cycles = 0;
   int                stall_left = 0;
   bit                no_gaps = 1'b0;

   bounded_fifo_with_search #(
      .QUEUE_DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] value
      .req_tuser  (req_tuser),   // [1:0] action
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] result_value
      .rsp_tuser  (rsp_tuser),   // [2:0] result_kind
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 10);
      else return $urandom_range(20, 60);
   endfunction

   function automatic int pick_req_gap();
      if (no_gaps || $urandom_range(0, 1) == 0) return 0;
      return pick_gap();
   endfunction

   function automatic logic [31:0] rand_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            default: return 32'h0;
         endcase
      end else if (r < 3) begin
         return $urandom_range(0, 15);
      end
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_query_value();
      int k;
      if (fifo_count > 0 && $urandom_range(0, 1) == 1) begin
         k = $urandom_range(0, fifo_count - 1);
         return fifo_mem[(fifo_head + k) % DEPTH];
      end
      return rand_value();
   endfunction

   function automatic void push_result(kind_type k, logic [31:0] v, logic l);
      result_type r;
      r.kind  = k;
      r.value = v;
      r.last  = l;
      pending_results.push_back(r);
   endfunction

   // predicts the results of one accepted action and updates the queue model
   function automatic void model_action(action_type act, logic [31:0] val);
      int  lim;
      int  slot;
      logic hit;
      lim = int'(cap_reg);
      if (lim > DEPTH) lim = DEPTH;
      if (lim > RESULT_LIMIT) lim = RESULT_LIMIT;
      case (act)
         ACT_ENQUEUE: begin
            if (fifo_count >= lim) begin
               push_result(KIND_OVERFLOW, 32'h0, 1'b1);
            end else begin
               fifo_mem[fifo_tail] = val;
               fifo_tail = (fifo_tail + 1) % DEPTH;
               fifo_count++;
               push_result(KIND_ENQUEUED, val, 1'b1);
            end
         end
         ACT_DEQUEUE: begin
            if (fifo_count == 0) begin
               push_result(KIND_UNDERFLOW, 32'h0, 1'b1);
            end else begin
               push_result(KIND_DEQUEUED, fifo_mem[fifo_head], 1'b1);
               fifo_head = (fifo_head + 1) % DEPTH;
               fifo_count--;
            end
         end
         ACT_QUERY: begin
            hit = 1'b0;
            slot = fifo_head;
            for (int i = 0; i < fifo_count; i++) begin
               if (fifo_mem[slot] == val) hit = 1'b1;
               slot = (slot + 1) % DEPTH;
            end
            push_result(hit ? KIND_FOUND : KIND_NOT_FOUND, val, 1'b1);
         end
         default: begin
            if (fifo_count == 0) begin
               push_result(KIND_DUMP_EMPTY, 32'h0, 1'b1);
            end else begin
               slot = fifo_head;
               for (int i = 0; i < fifo_count && i < RESULT_LIMIT; i++) begin
                  push_result(KIND_DUMP_ENTRY, fifo_mem[slot],
                              (i + 1 == fifo_count) || (i + 1 == RESULT_LIMIT));
                  slot = (slot + 1) % DEPTH;
               end
               if (fifo_count > longest_dump) longest_dump = fifo_count;
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (error_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // result checker, receiver stalls and idle counter
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: unexpected result, expected none actual kind %h value %h",
                           $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("value", want.value, rsp_tdata);
               check_field("last", 32'(want.last), 32'(rsp_tlast));
               results_checked++;
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (no_gaps) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= pick_gap() - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_action(action_type act, logic [31:0] val);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_action(act, val);
      items_sent++;
      gap = pick_req_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we  <= 1'b0;
      cap_reg = cap;
      cap_writes++;
   endtask

   task automatic test_empty_queue();
      send_action(ACT_DEQUEUE, 32'hffff_ffff);
      send_action(ACT_DUMP, 32'h1234_5678);
      send_action(ACT_QUERY, 32'h8000_0000);
   endtask

   task automatic test_value_extremes();
      send_action(ACT_ENQUEUE, 32'h7fff_ffff);
      send_action(ACT_ENQUEUE, 32'h8000_0000);
      send_action(ACT_ENQUEUE, 32'h0000_0000);
      send_action(ACT_ENQUEUE, 32'hffff_ffff);
      send_action(ACT_QUERY, 32'h8000_0000);
      send_action(ACT_QUERY, 32'h7fff_fffe);
      send_action(ACT_DUMP, 32'h0);
      repeat (4) send_action(ACT_DEQUEUE, 32'h0);
      send_action(ACT_DEQUEUE, 32'h0);
   endtask

   task automatic test_capacity_shrink();
      write_capacity(6'd1);
      send_action(ACT_ENQUEUE, 32'h0000_00a1);
      send_action(ACT_ENQUEUE, 32'h0000_00b2);
      write_capacity(6'd63);
      send_action(ACT_ENQUEUE, 32'hc3c3_c3c3);
      send_action(ACT_ENQUEUE, 32'hd4d4_d4d4);
      // limit now below the stored count
      write_capacity(6'd1);
      send_action(ACT_ENQUEUE, 32'he5e5_e5e5);
      send_action(ACT_DEQUEUE, 32'h0);
      send_action(ACT_DEQUEUE, 32'h0);
      send_action(ACT_ENQUEUE, 32'hf6f6_f6f6);
      send_action(ACT_DEQUEUE, 32'h0);
      send_action(ACT_ENQUEUE, 32'h0707_0707);
      send_action(ACT_DUMP, 32'h0);
      send_action(ACT_DEQUEUE, 32'h0);
   endtask

   task automatic test_fill_and_drain();
      write_capacity(6'd63);
      no_gaps = 1'b1;
      while (fifo_count < RESULT_LIMIT) send_action(ACT_ENQUEUE, rand_value());
      send_action(ACT_ENQUEUE, rand_value());
      send_action(ACT_DUMP, rand_value());
      send_action(ACT_QUERY, pick_query_value());
      send_action(ACT_QUERY, rand_value());
      no_gaps = 1'b0;
      while (fifo_count > 0) send_action(ACT_DEQUEUE, rand_value());
      send_action(ACT_DEQUEUE, rand_value());
   endtask

   task automatic run_mix(int count, int enq_pct, int deq_pct);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < enq_pct) send_action(ACT_ENQUEUE, rand_value());
         else if (r < enq_pct + deq_pct) send_action(ACT_DEQUEUE, rand_value());
         else if ($urandom_range(0, 1) == 0) send_action(ACT_QUERY, pick_query_value());
         else send_action(ACT_DUMP, rand_value());
      end
   endtask

   task automatic test_random_mix();
      int caps [7] = '{32, 63, 1, 0, -1, 17, 32};
      int enqs [7] = '{55, 70, 50, 40, 50, 65, 30};
      for (int p = 0; p < 7; p++) begin
         if (caps[p] < 0) write_capacity(CAP_W'($urandom_range(0, 63)));
         else write_capacity(CAP_W'(caps[p]));
         no_gaps = (p == 5);
         run_mix(35, enqs[p], 20);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_value_extremes();
      test_capacity_shrink();
      test_fill_and_drain();
      test_random_mix();
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d actions, checked %0d results over %0d capacity settings",
               items_sent, results_checked, cap_writes);
      $display("longest dump %0d entries, %0d mismatches", longest_dump, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
